[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int POOL_BYTES_DEF = 4096;
	localparam int HDR_BYTES      = 4;
	localparam int SIZE_W         = 16;
	localparam int POS_W          = SIZE_W + 2;
	localparam int REQ_W          = 13;
	localparam int OFF_W          = 13;
	localparam int RES_W          = 12;
	localparam int ST_W           = 2;
	localparam int PROBE_W        = 8;
	localparam int S_TDATA_W      = 32;
	localparam int M_TDATA_W      = 16;

	localparam logic [PROBE_W-1:0] MAX_PROBES_RST = 8'd100;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [ST_W-1:0] {
		RS_OK      = 2'd0,
		RS_NOFIT   = 2'd1,
		RS_BADFREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_A_RD,
		S_A_CHK,
		S_A_SPLIT,
		S_F_RD,
		S_F_CHK,
		S_F_NXT,
		S_F_MRG,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                used;
		logic [SIZE_W-1:0]   size;
	} hdr_t;

	typedef struct packed {
		logic    load;
		logic    set_st;
		status_t st;
		logic    rd_pos;
		logic    rd_nxt;
		logic    step;
		logic    wr_alloc;
		logic    wr_split;
		logic    free_init;
		logic    wr_free;
		logic    wr_merge;
		logic    push;
	} cmd_t;

	typedef struct packed {
		logic op_free;
		logic req_zero;
		logic free_bad;
		logic walk_ok;
		logic fit;
		logic split;
		logic split_in;
		logic nxt_in;
		logic nxt_free;
		logic out_busy;
	} sts_t;

endpackage

[hw/rtl/ffpa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer for allocate walks and free/merge updates.
// ----------------------------------------------------------------------------
module ffpa_ctrl
	import ffpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.st  = RS_OK;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.op_free) begin
					if (sts.free_bad) begin
						cmd.set_st = 1'b1;
						cmd.st     = RS_BADFREE;
						state_d    = S_FIN;
					end else begin
						cmd.free_init = 1'b1;
						state_d       = S_F_RD;
					end
				end else if (sts.req_zero) begin
					cmd.set_st = 1'b1;
					cmd.st     = RS_NOFIT;
					state_d    = S_FIN;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_RD: begin
				if (sts.walk_ok) begin
					cmd.rd_pos = 1'b1;
					state_d    = S_A_CHK;
				end else begin
					cmd.set_st = 1'b1;
					cmd.st     = RS_NOFIT;
					state_d    = S_FIN;
				end
			end
			S_A_CHK: begin
				if (sts.fit) begin
					cmd.wr_alloc = 1'b1;
					if (sts.split && sts.split_in) begin
						state_d = S_A_SPLIT;
					end else begin
						cmd.set_st = 1'b1;
						cmd.st     = RS_OK;
						state_d    = S_FIN;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = S_A_RD;
				end
			end
			S_A_SPLIT: begin
				cmd.wr_split = 1'b1;
				cmd.set_st   = 1'b1;
				cmd.st       = RS_OK;
				state_d      = S_FIN;
			end
			S_F_RD: begin
				cmd.rd_pos = 1'b1;
				state_d    = S_F_CHK;
			end
			S_F_CHK: begin
				cmd.wr_free = 1'b1;
				state_d     = S_F_NXT;
			end
			S_F_NXT: begin
				if (sts.nxt_in) begin
					cmd.rd_nxt = 1'b1;
					state_d    = S_F_MRG;
				end else begin
					cmd.set_st = 1'b1;
					cmd.st     = RS_OK;
					state_d    = S_FIN;
				end
			end
			S_F_MRG: begin
				cmd.wr_merge = sts.nxt_free;
				cmd.set_st   = 1'b1;
				cmd.st       = RS_OK;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/ffpa_dp.sv]
// ----------------------------------------------------------------------------
// ffpa_dp
// Header store, walk registers, compares and the result register.
// ----------------------------------------------------------------------------
module ffpa_dp
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES = POOL_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [PROBE_W-1:0]   cfg_wdata,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [ST_W-1:0]      m_tuser,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam int AW = $clog2(POOL_BYTES);
	localparam logic [POS_W-1:0] POOL_P = POS_W'(POOL_BYTES);
	localparam logic [POS_W-1:0] HDR_P  = POS_W'(HDR_BYTES);

	hdr_t                hdr_mem [POOL_BYTES];
	hdr_t                rd_q;
	logic                rd_is0_q;
	hdr_t                hdr0_q;
	hdr_t                rd_hdr;

	logic [PROBE_W-1:0]  max_probes_q;
	op_t                 op_q;
	logic [REQ_W-1:0]    req_q;
	logic [OFF_W-1:0]    doff_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    nxt_q;
	logic [SIZE_W-1:0]   sz_q;
	logic [PROBE_W-1:0]  probes_q;
	status_t             res_st_q;

	logic                m_tvalid_q;
	status_t             m_st_q;
	logic [RES_W-1:0]    m_off_q;

	logic [POS_W-1:0]    req_p;
	logic [POS_W-1:0]    rsz_p;
	logic [POS_W-1:0]    doff_p;
	logic [POS_W-1:0]    alloc_nxt;
	logic [POS_W-1:0]    free_nxt;
	logic [POS_W-1:0]    merged;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	hdr_t                wr_data;

	assign req_p     = POS_W'(req_q);
	assign rsz_p     = POS_W'(rd_hdr.size);
	assign doff_p    = POS_W'(doff_q);
	assign alloc_nxt = pos_q + HDR_P + req_p;
	assign free_nxt  = pos_q + HDR_P + rsz_p;
	assign merged    = POS_W'(sz_q) + HDR_P + rsz_p;

	assign rd_hdr = rd_is0_q ? hdr0_q : rd_q;

	// header store; entry 0 lives in flops so it has a reset value
	assign rd_en   = cmd.rd_pos | cmd.rd_nxt;
	assign rd_addr = cmd.rd_nxt ? nxt_q[AW-1:0] : pos_q[AW-1:0];
	assign wr_en   = cmd.wr_alloc | cmd.wr_split | cmd.wr_free | cmd.wr_merge;
	assign wr_addr = cmd.wr_split ? nxt_q[AW-1:0] : pos_q[AW-1:0];

	always_comb begin
		wr_data.used = 1'b0;
		wr_data.size = rd_hdr.size;
		if (cmd.wr_alloc) begin
			wr_data.used = 1'b1;
			if (sts.split) begin
				wr_data.size = SIZE_W'(req_q);
			end
		end else if (cmd.wr_split) begin
			wr_data.size = sz_q;
		end else if (cmd.wr_merge) begin
			wr_data.size = merged[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr != '0)) begin
			hdr_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q     <= hdr_mem[rd_addr];
			rd_is0_q <= (rd_addr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_q.used  <= 1'b0;
			hdr0_q.size  <= SIZE_W'(POOL_BYTES - HDR_BYTES);
			max_probes_q <= MAX_PROBES_RST;
		end else begin
			if (wr_en && (wr_addr == '0)) begin
				hdr0_q <= wr_data;
			end
			if (cfg_wen) begin
				max_probes_q <= cfg_wdata;
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(s_tuser);
			req_q    <= s_tdata[REQ_W-1:0];
			doff_q   <= s_tdata[REQ_W+OFF_W-1:REQ_W];
			pos_q    <= '0;
			probes_q <= '0;
		end else if (cmd.free_init) begin
			pos_q <= doff_p - HDR_P;
		end else if (cmd.step) begin
			pos_q    <= free_nxt;
			probes_q <= probes_q + PROBE_W'(1);
		end
		if (cmd.wr_alloc) begin
			nxt_q <= alloc_nxt;
			sz_q  <= SIZE_W'(rsz_p - req_p - HDR_P);
		end else if (cmd.wr_free) begin
			nxt_q <= free_nxt;
			sz_q  <= rd_hdr.size;
		end
		if (cmd.set_st) begin
			res_st_q <= cmd.st;
		end
	end

	assign sts.op_free  = (op_q == OP_FREE);
	assign sts.req_zero = (req_q == '0);
	assign sts.free_bad = (doff_p < HDR_P) || ((doff_p - HDR_P) >= POOL_P);
	assign sts.walk_ok  = (pos_q < POOL_P) && (probes_q < max_probes_q);
	assign sts.fit      = !rd_hdr.used && (rsz_p >= req_p);
	assign sts.split    = rsz_p > (req_p + HDR_P);
	assign sts.split_in = alloc_nxt < POOL_P;
	assign sts.nxt_in   = nxt_q < POOL_P;
	assign sts.nxt_free = !rd_hdr.used;
	assign sts.out_busy = m_tvalid_q && !m_tready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			m_st_q <= res_st_q;
			if ((res_st_q == RS_OK) && (op_q == OP_ALLOC)) begin
				m_off_q <= RES_W'(pos_q + HDR_P);
			end else begin
				m_off_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_st_q;
	assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, m_off_q};

endmodule

[hw/rtl/first_fit_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// First-fit allocator over a byte pool tiled by 4-byte block headers.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                  tuser
//  s_*      in   [12:0] request_size, [25:13] data_offset op
//  m_*      out  [11:0] result_offset                   status
//  cfg_*    in   cfg_wdata = max_probes, written on cfg_wen
//
//  Allocate: one header read and fit check per header probed, an extra step
//  when the walk ends without a fit, another for a split header. Free: mark
//  the header free, merge a free following header inside the pool; an offset
//  outside the pool fails at dispatch. A stalled result holds the item at the
//  end. One item in flight; the next is taken once the result is registered.
//  Reset leaves one free block at offset 0; other headers are unset.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_core
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES = POOL_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [PROBE_W-1:0]   cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // request_size, data_offset
	input  logic                 s_tuser,   // op
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // result_offset
	output logic [ST_W-1:0]      m_tuser    // status
);

	cmd_t cmd;
	sts_t sts;

	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffpa_dp #(
		.POOL_BYTES (POOL_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[hw/rtl/ffpa_checker.sv]
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffpa_checker
	import ffpa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [ST_W-1:0]      m_tuser
);

	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	`CHK_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")

	`CHK_IMPLY(a_status_code, m_tvalid, (m_tuser == RS_OK) || (m_tuser == RS_NOFIT) || (m_tuser == RS_BADFREE), "bad status code")

	`CHK_IMPLY(a_fail_zero, m_tvalid && (m_tuser != RS_OK), m_tdata == '0, "failed item with nonzero offset")

endmodule

bind first_fit_pool_allocator_core ffpa_checker u_ffpa_checker (.*);
